// File: rtl/ccb_pkg.sv
// Shared types and constants for the C comment blanker.
`default_nettype none
package ccb_pkg;

  // Line counter width and saturation value
  localparam int LINE_BITS = 20;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // Output queue sizing
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  // Scanner modes
  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_SLASH = 5'b00010,
    MODE_LINE  = 5'b00100,
    MODE_BLOCK = 5'b01000,
    MODE_STAR  = 5'b10000
  } scan_mode_t;

  // One output byte with its end-of-text status
  typedef struct packed {
    logic [7:0]           ch;
    logic                 last;
    logic                 unclosed;
    logic [LINE_BITS-1:0] start_line;
    logic [LINE_BITS-1:0] line_count;
  } out_item_t;

  // Bytes produced by one input transfer (0, 1 or 2)
  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } scan_push_t;

  // Queue status toward the top level
  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 room2;
  } queue_stat_t;

endpackage
`default_nettype wire

// File: rtl/ccb_scanner.sv
// Comment scanner: mode and line state, produces up to two bytes per input.
`default_nettype none
module ccb_scanner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [7:0]                    in_char,
  input  wire logic                          end_of_text,
  output ccb_pkg::scan_push_t                push
);

  ccb_pkg::scan_mode_t                 mode, mode_next, mode_upd;
  logic [ccb_pkg::LINE_BITS-1:0]       cur_line, line_upd;
  logic [ccb_pkg::LINE_BITS-1:0]       open_line, open_upd;
  logic [7:0]                          ch0, ch1;
  logic [1:0]                          n;
  logic                                is_nl, is_slash, is_star, open_now;
  ccb_pkg::out_item_t                  fin;

  assign is_nl    = (in_char == ccb_pkg::CH_NEWLINE);
  assign is_slash = (in_char == ccb_pkg::CH_SLASH);
  assign is_star  = (in_char == ccb_pkg::CH_STAR);

  // Mode transition and emitted bytes
  always_comb begin
    mode_upd = mode;
    open_upd = open_line;
    n        = 2'd1;
    ch0      = ccb_pkg::CH_SPACE;
    ch1      = ccb_pkg::CH_SPACE;
    case (mode)
      ccb_pkg::MODE_SLASH: begin
        n = 2'd2;
        if (is_star) begin
          mode_upd = ccb_pkg::MODE_BLOCK;
          open_upd = cur_line;
        end else if (is_slash) begin
          mode_upd = ccb_pkg::MODE_LINE;
        end else begin
          ch0      = ccb_pkg::CH_SLASH;
          ch1      = in_char;
          mode_upd = ccb_pkg::MODE_PLAIN;
        end
      end
      ccb_pkg::MODE_LINE: begin
        if (is_nl) begin
          ch0      = ccb_pkg::CH_NEWLINE;
          mode_upd = ccb_pkg::MODE_PLAIN;
        end
      end
      ccb_pkg::MODE_BLOCK: begin
        if (is_nl) begin
          ch0 = ccb_pkg::CH_NEWLINE;
        end else if (is_star) begin
          mode_upd = ccb_pkg::MODE_STAR;
        end
      end
      ccb_pkg::MODE_STAR: begin
        if (is_nl) begin
          ch0      = ccb_pkg::CH_NEWLINE;
          mode_upd = ccb_pkg::MODE_BLOCK;
        end else if (is_slash) begin
          mode_upd = ccb_pkg::MODE_PLAIN;
        end else if (!is_star) begin
          mode_upd = ccb_pkg::MODE_BLOCK;
        end
      end
      default: begin
        mode_upd = ccb_pkg::MODE_PLAIN;
        if (is_slash && !end_of_text) begin
          mode_upd = ccb_pkg::MODE_SLASH;
          n        = 2'd0;
        end else begin
          ch0 = in_char;
        end
      end
    endcase
  end

  // Saturating line counter
  assign line_upd = (is_nl && cur_line != ccb_pkg::LINE_MAX) ?
                    cur_line + ccb_pkg::LINE_ONE : cur_line;

  assign open_now = (mode_upd == ccb_pkg::MODE_BLOCK) || (mode_upd == ccb_pkg::MODE_STAR);

  // Final byte carries the end-of-text report
  always_comb begin
    fin.ch         = (n == 2'd2) ? ch1 : ch0;
    fin.last       = 1'b1;
    fin.unclosed   = open_now;
    fin.start_line = open_now ? open_upd : '0;
    fin.line_count = line_upd;
  end

  always_comb begin
    push.n     = n;
    push.item0 = '{ch: ch0, last: 1'b0, unclosed: 1'b0, start_line: '0, line_count: '0};
    push.item1 = '{ch: ch1, last: 1'b0, unclosed: 1'b0, start_line: '0, line_count: '0};
    if (end_of_text) begin
      if (n == 2'd2) begin
        push.item1 = fin;
      end else begin
        push.item0 = fin;
      end
    end
  end

  // State registers; end of text returns to the start-of-text state
  always_comb begin
    mode_next = mode_upd;
    if (end_of_text) begin
      mode_next = ccb_pkg::MODE_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ccb_pkg::MODE_PLAIN;
      cur_line  <= ccb_pkg::LINE_ONE;
      open_line <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      cur_line  <= end_of_text ? ccb_pkg::LINE_ONE : line_upd;
      open_line <= end_of_text ? '0 : open_upd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccb_out_queue.sv
// Output queue: takes up to two bytes per cycle, hands out one per cycle while pop is high.
`default_nettype none
module ccb_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_en,
  input  wire ccb_pkg::scan_push_t  push,
  input  wire logic                 pop,
  output ccb_pkg::out_item_t        head,
  output logic                      head_valid,
  output ccb_pkg::queue_stat_t      stat
);

  ccb_pkg::out_item_t             entries [ccb_pkg::QDEPTH];
  logic [ccb_pkg::QPTR_BITS-1:0]  wr_ptr, rd_ptr, wr_ptr1;
  logic [ccb_pkg::QCNT_BITS-1:0]  count, count_next;
  logic [1:0]                     n_in;

  assign n_in    = push_en ? push.n : 2'd0;
  assign wr_ptr1 = wr_ptr + ccb_pkg::QPTR_BITS'(1);

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);

  assign stat.count = count;
  assign stat.room2 = (count <= ccb_pkg::QCNT_BITS'(ccb_pkg::QDEPTH - 2));

  assign count_next = count + ccb_pkg::QCNT_BITS'(n_in)
                      - ccb_pkg::QCNT_BITS'(pop && head_valid);

  // Entry storage
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      entries[wr_ptr] <= push.item0;
    end
    if (n_in == 2'd2) begin
      entries[wr_ptr1] <= push.item1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ccb_pkg::QPTR_BITS'(n_in);
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + ccb_pkg::QPTR_BITS'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/c_comment_blanker_top.sv
// Top level of the C comment blanker: scanner feeding the output queue.
`default_nettype none
// Streams source text one byte per transfer and returns the same number of
// bytes, with block and line comments turned into spaces and newlines kept.
// A slash in plain text is held until the next byte, so one input may give
// zero, one or two output bytes; these go into a four-entry output queue.
// The block takes an input whenever the queue has two free slots, which
// sustains one byte per cycle when the output side keeps up; in_ready does
// not depend on out_ready in the same cycle. The byte flagged end_of_text
// produces the last output byte, which carries the line count and the
// unclosed-comment report, and the scanner then starts a fresh text.
module c_comment_blanker_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_char,
  input  wire logic                          end_of_text,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_char,
  output logic                               last_out,
  output logic                               unclosed_comment,
  output logic [ccb_pkg::LINE_BITS-1:0]      comment_start_line,
  output logic [ccb_pkg::LINE_BITS-1:0]      line_count
);

  logic                  in_xfer;
  ccb_pkg::scan_push_t   push;
  ccb_pkg::out_item_t    head;
  ccb_pkg::queue_stat_t  stat;

  assign in_ready = stat.room2;
  assign in_xfer  = in_valid && in_ready;

  ccb_scanner u_scanner (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_xfer),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .push        (push)
  );

  ccb_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (in_xfer),
    .push       (push),
    .pop        (out_ready),
    .head       (head),
    .head_valid (out_valid),
    .stat       (stat)
  );

  // Output fields from the queue head
  assign out_char           = head.ch;
  assign last_out           = head.last;
  assign unclosed_comment   = head.unclosed;
  assign comment_start_line = head.start_line;
  assign line_count         = head.line_count;

`ifndef SYNTHESIS
  // Final byte of a text always produces at least one output byte
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_xfer && end_of_text |-> push.n != 2'd0)
    else $error("end of text produced no output byte");

  // Queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.count <= ccb_pkg::QCNT_BITS'(ccb_pkg::QDEPTH))
    else $error("output queue overflow");

  // A two-byte push lands in a queue that had room for both
  a_room_on_push: assert property (@(posedge clk) disable iff (rst)
    in_xfer && push.n == 2'd2 |=>
      stat.count <= ccb_pkg::QCNT_BITS'(ccb_pkg::QDEPTH))
    else $error("two-byte push without room");

  // Queue holds data exactly when a result is offered
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    out_valid == (stat.count != '0))
    else $error("out_valid does not match queue fill");
`endif

endmodule
`default_nettype wire

// File: test/tb_c_comment_blanker_top.sv
// Testbench for c_comment_blanker_top: random and directed text checked against a predictor.
`timescale 1ns / 1ps
module tb_c_comment_blanker_top;

  // Random part stops once this many items have gone in
  localparam int  RANDOM_ITEMS = 1350;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  MAX_PRINTS   = 30;
  // About 1400 items in all, each with random gaps on the sender and receiver sides.
  // The limit leaves a wide margin over that.
  localparam longint CYCLE_LIMIT = 200_000;

  // Predicts the blanked byte stream and holds the bytes still to come out
  class blanker_scoreboard;
    ccb_pkg::scan_mode_t           mode;
    logic [ccb_pkg::LINE_BITS-1:0] line_no;
    logic [ccb_pkg::LINE_BITS-1:0] open_line;
    ccb_pkg::out_item_t            pending_bytes[$];
    int                            errors;
    int                            checked;

    function new();
      errors  = 0;
      checked = 0;
      clear_text();
    endfunction

    function void clear_text();
      mode      = ccb_pkg::MODE_PLAIN;
      line_no   = ccb_pkg::LINE_ONE;
      open_line = '0;
    endfunction

    function void emit_byte(logic [7:0] ch);
      ccb_pkg::out_item_t b;
      b            = '0;
      b.ch         = ch;
      pending_bytes.push_back(b);
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    // Note an accepted input transfer and queue the bytes it causes
    function void note_input(logic [7:0] c, logic eot);
      int n;
      int idx;
      logic open_now;
      n = pending_bytes.size();
      case (mode)
        ccb_pkg::MODE_SLASH: begin
          if (c == ccb_pkg::CH_STAR) begin
            emit_byte(ccb_pkg::CH_SPACE);
            emit_byte(ccb_pkg::CH_SPACE);
            mode      = ccb_pkg::MODE_BLOCK;
            open_line = line_no;
          end else if (c == ccb_pkg::CH_SLASH) begin
            emit_byte(ccb_pkg::CH_SPACE);
            emit_byte(ccb_pkg::CH_SPACE);
            mode = ccb_pkg::MODE_LINE;
          end else begin
            emit_byte(ccb_pkg::CH_SLASH);
            emit_byte(c);
            mode = ccb_pkg::MODE_PLAIN;
          end
        end
        ccb_pkg::MODE_LINE: begin
          if (c == ccb_pkg::CH_NEWLINE) begin
            emit_byte(ccb_pkg::CH_NEWLINE);
            mode = ccb_pkg::MODE_PLAIN;
          end else begin
            emit_byte(ccb_pkg::CH_SPACE);
          end
        end
        ccb_pkg::MODE_BLOCK: begin
          if (c == ccb_pkg::CH_NEWLINE) begin
            emit_byte(ccb_pkg::CH_NEWLINE);
          end else begin
            emit_byte(ccb_pkg::CH_SPACE);
            if (c == ccb_pkg::CH_STAR) mode = ccb_pkg::MODE_STAR;
          end
        end
        ccb_pkg::MODE_STAR: begin
          if (c == ccb_pkg::CH_NEWLINE) begin
            emit_byte(ccb_pkg::CH_NEWLINE);
            mode = ccb_pkg::MODE_BLOCK;
          end else begin
            emit_byte(ccb_pkg::CH_SPACE);
            if (c == ccb_pkg::CH_SLASH) mode = ccb_pkg::MODE_PLAIN;
            else if (c != ccb_pkg::CH_STAR) mode = ccb_pkg::MODE_BLOCK;
          end
        end
        default: begin
          // slash on the final byte is passed straight through
          if (c == ccb_pkg::CH_SLASH && !eot) begin
            mode = ccb_pkg::MODE_SLASH;
          end else begin
            emit_byte(c);
            mode = ccb_pkg::MODE_PLAIN;
          end
        end
      endcase

      if (c == ccb_pkg::CH_NEWLINE && line_no != ccb_pkg::LINE_MAX)
        line_no = line_no + ccb_pkg::LINE_ONE;

      // end of text: status rides on the last byte, then a fresh text starts
      if (eot && pending_bytes.size() > n) begin
        idx      = pending_bytes.size() - 1;
        open_now = (mode == ccb_pkg::MODE_BLOCK) || (mode == ccb_pkg::MODE_STAR);
        pending_bytes[idx].last       = 1'b1;
        pending_bytes[idx].unclosed   = open_now;
        pending_bytes[idx].start_line = open_now ? open_line : '0;
        pending_bytes[idx].line_count = line_no;
        clear_text();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // Compare one output transfer with the oldest expected byte
    task check_output(ccb_pkg::out_item_t got);
      ccb_pkg::out_item_t want;
      checked++;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %0d: unexpected output ch=%02h", checked, got.ch));
      end else begin
        want = pending_bytes.pop_front();
        if (got.ch !== want.ch)
          report($sformatf("byte %0d: out_char %02h, want %02h", checked, got.ch, want.ch));
        if (got.last !== want.last)
          report($sformatf("byte %0d: last_out %b, want %b", checked, got.last, want.last));
        if (got.unclosed !== want.unclosed)
          report($sformatf("byte %0d: unclosed_comment %b, want %b",
                           checked, got.unclosed, want.unclosed));
        if (got.start_line !== want.start_line)
          report($sformatf("byte %0d: comment_start_line %0d, want %0d",
                           checked, got.start_line, want.start_line));
        if (got.line_count !== want.line_count)
          report($sformatf("byte %0d: line_count %0d, want %0d",
                           checked, got.line_count, want.line_count));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_char     = 8'h00;
  logic                          end_of_text = 1'b0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [7:0]                    out_char;
  logic                          last_out;
  logic                          unclosed_comment;
  logic [ccb_pkg::LINE_BITS-1:0] comment_start_line;
  logic [ccb_pkg::LINE_BITS-1:0] line_count;

  blanker_scoreboard sb = new();
  logic [7:0]        text_q[$];
  bit                no_idle    = 1'b0;
  int                items_sent = 0;
  longint            cycle_count = 0;

  c_comment_blanker_top u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char            (in_char),
    .end_of_text        (end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .last_out           (last_out),
    .unclosed_comment   (unclosed_comment),
    .comment_start_line (comment_start_line),
    .line_count         (line_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Byte mix biased toward the characters that steer the scanner
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return ccb_pkg::CH_SLASH;
    if (r < 36) return ccb_pkg::CH_STAR;
    if (r < 48) return ccb_pkg::CH_NEWLINE;
    if (r < 58) return 8'($urandom_range(0, 255));
    if (r < 64) return ccb_pkg::CH_SPACE;
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] pick_code_char();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return ccb_pkg::CH_SLASH;
    if (r == 1) return ccb_pkg::CH_STAR;
    if (r == 2) return ccb_pkg::CH_SPACE;
    return 8'($urandom_range(8'h30, 8'h7A));
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Mostly code, block comments and line comments with random bodies
  function automatic void build_structured_text();
    int segs;
    logic [7:0] b;
    segs = $urandom_range(1, 6);
    repeat (segs) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 6)) text_q.push_back(pick_code_char());
        1: begin
          add_str("/*");
          repeat ($urandom_range(0, 10)) text_q.push_back(pick_char());
          // now and then leave the comment open
          if ($urandom_range(0, 7) != 0) add_str("*/");
        end
        2: begin
          add_str("//");
          repeat ($urandom_range(0, 8)) begin
            b = pick_char();
            text_q.push_back(b == ccb_pkg::CH_NEWLINE ? ccb_pkg::CH_STAR : b);
          end
          text_q.push_back(ccb_pkg::CH_NEWLINE);
        end
        default: text_q.push_back(ccb_pkg::CH_NEWLINE);
      endcase
    end
  endfunction

  function automatic void build_noise_text();
    repeat ($urandom_range(1, 40)) text_q.push_back(pick_char());
  endfunction

  // One input transfer, with a random gap in front unless idling is off
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= c;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    sb.note_input(c, eot);
    items_sent++;
  endtask

  // Sends the built text with the end flag on its last byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Output side: random stalls per transfer, each transfer checked
  initial begin
    ccb_pkg::out_item_t got;
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.ch         = out_char;
      got.last       = last_out;
      got.unclosed   = unclosed_comment;
      got.start_line = comment_start_line;
      got.line_count = line_count;
      sb.check_output(got);
    end
  end

  // Stimulus
  initial begin
    int directed_items;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme bytes, slash held before other byte, slash as final byte
    text_q.push_back(8'h00);
    text_q.push_back(ccb_pkg::CH_SLASH);
    text_q.push_back(8'hFF);
    text_q.push_back(ccb_pkg::CH_SLASH);
    send_text();
    // opener star cannot close, nested openers ignored, line comment keeps newline
    add_str("/*/ //\n*/x//a/*\nb");
    send_text();
    // block comment still open at end of text
    add_str("/*");
    send_text();
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) build_noise_text();
      else build_structured_text();
      send_text();
    end
    in_valid <= 1'b0;

    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
